// File: rtl/ntt_mm_pkg.sv
// Shared constants and types for the NTT-domain matrix multiply-accumulate block.
// Used by the top level and the remainder pipeline; depends on nothing else.
package ntt_mm_pkg;

   localparam int NUM_COEFFS_DEF = 2048;
   localparam int NUM_SLOTS_DEF  = 2;

   localparam int COEFF_W   = 32;
   localparam int MOD_W     = 32;
   localparam int SUM_W     = 64;
   localparam int POS_W     = 11;
   localparam int CSR_IDX_W = 2;

   // Dividend bits retired per remainder pipeline stage.
   localparam int STEP_BITS = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MOD_FIRST    = 2'd0,
      CSR_MOD_SECOND   = 2'd1,
      CSR_REDUCE_EACH  = 2'd2,
      CSR_FINAL_REDUCE = 2'd3
   } csr_index_type;

endpackage

// File: rtl/ntt_mm_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stands alone; no package needed.
module ntt_mm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ntt_mm_mod_pipe.sv
// Pipelined restoring remainder unit: a 64-bit value modulo a 32-bit modulus.
// A zero modulus or the bypass flag passes the value through. Uses ntt_mm_pkg.
module ntt_mm_mod_pipe #(
   parameter int TAG_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [ntt_mm_pkg::SUM_W-1:0] in_value,
   input  logic [ntt_mm_pkg::MOD_W-1:0] in_mod,
   input  logic                        in_bypass,
   input  logic [TAG_W-1:0]            in_tag,
   output logic                        out_valid,
   output logic [ntt_mm_pkg::SUM_W-1:0] out_value,
   output logic [TAG_W-1:0]            out_tag
);

   localparam int VW     = ntt_mm_pkg::SUM_W;
   localparam int MW     = ntt_mm_pkg::MOD_W;
   localparam int SB     = ntt_mm_pkg::STEP_BITS;
   localparam int STAGES = VW / SB;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [MW-1:0]     rem_ff  [STAGES];
   logic [MW-1:0]     rem_in  [STAGES];
   logic [VW-1:0]     num_ff  [STAGES];
   logic [VW-1:0]     num_in  [STAGES];
   logic [VW-1:0]     orig_ff [STAGES];
   logic [VW-1:0]     orig_in [STAGES];
   logic [MW-1:0]     mod_ff  [STAGES];
   logic [MW-1:0]     mod_in  [STAGES];
   logic [STAGES-1:0] byp_ff, byp_in;
   logic [TAG_W-1:0]  tag_ff  [STAGES];
   logic [TAG_W-1:0]  tag_in  [STAGES];

   // Each stage shifts SB dividend bits into the partial remainder, with a
   // conditional subtract after each bit.
   always_comb begin
      logic [MW-1:0] rem;
      logic [VW-1:0] num;
      logic [MW:0]   trial;
      for (int k = 0; k < STAGES; k++) begin
         if (k == 0) begin
            valid_in[k] = in_valid;
            rem         = '0;
            num         = in_value;
            orig_in[k]  = in_value;
            mod_in[k]   = in_mod;
            byp_in[k]   = in_bypass;
            tag_in[k]   = in_tag;
         end else begin
            valid_in[k] = valid_ff[k-1];
            rem         = rem_ff[k-1];
            num         = num_ff[k-1];
            orig_in[k]  = orig_ff[k-1];
            mod_in[k]   = mod_ff[k-1];
            byp_in[k]   = byp_ff[k-1];
            tag_in[k]   = tag_ff[k-1];
         end
         for (int j = 0; j < SB; j++) begin
            trial = {rem, num[VW-1]};
            num   = num << 1;
            if (trial >= {1'b0, mod_in[k]}) begin
               trial = trial - {1'b0, mod_in[k]};
            end
            rem = trial[MW-1:0];
         end
         rem_in[k] = rem;
         num_in[k] = num;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         orig_ff <= orig_in;
         mod_ff  <= mod_in;
         byp_ff  <= byp_in;
         tag_ff  <= tag_in;
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_tag   = tag_ff[STAGES-1];
   assign out_value = (byp_ff[STAGES-1] || (mod_ff[STAGES-1] == '0))
                      ? orig_ff[STAGES-1]
                      : {{(VW-MW){1'b0}}, rem_ff[STAGES-1]};

endmodule

// File: rtl/ntt_poly_matrix_mod_mac_top.sv
// Stages: input, multiply, product remainder, q, w, final remainder, output register.
// Throughput while not halted: one request word per cycle; the accumulator RAM is read
// and written once per word and each remainder pipeline takes a new value every cycle.
// Reset: synchronous; clears pipeline valids and sets moduli to 1 and both
// reduction flags on. The accumulator RAM is not cleared; first_term restarts an entry.
module ntt_poly_matrix_mod_mac_top #(
   parameter int NUM_COEFFS = ntt_mm_pkg::NUM_COEFFS_DEF,
   parameter int NUM_SLOTS  = ntt_mm_pkg::NUM_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ntt_mm_pkg::COEFF_W-1:0]    req_left_coeff,
   input  logic [ntt_mm_pkg::COEFF_W-1:0]    req_right_coeff,
   input  logic                              req_residue_slot,
   input  logic [ntt_mm_pkg::POS_W-1:0]      req_coeff_position,
   input  logic                              req_first_term,
   input  logic                              req_last_term,
   // Response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ntt_mm_pkg::SUM_W-1:0]      rsp_sum_value,
   output logic                              rsp_sum_slot,
   output logic [ntt_mm_pkg::POS_W-1:0]      rsp_sum_position,
   // Register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ntt_mm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ntt_mm_pkg::MOD_W-1:0]      csr_data
);

   localparam int DEPTH  = NUM_SLOTS * NUM_COEFFS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW     = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;
   localparam int CW     = ntt_mm_pkg::COEFF_W;
   localparam int MW     = ntt_mm_pkg::MOD_W;
   localparam int SW     = ntt_mm_pkg::SUM_W;
   localparam int POSW   = ntt_mm_pkg::POS_W;
   localparam int RW     = POSW + 14;
   // Tag through the product remainder pipe: address, wrapped slot, slot,
   // position, first, last.
   localparam int TAGA_W = ADDR_W + 1 + 1 + POSW + 2;
   localparam int TAGB_W = 1 + POSW;

   // ---------------------------------------------------------------------
   // Registers; the user must write them only while the block is idle; the block does not enforce this.
   // ---------------------------------------------------------------------
   logic [MW-1:0] mod_first_ff, mod_second_ff;
   logic          reduce_each_ff, final_reduce_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_first_ff    <= MW'(1);
         mod_second_ff   <= MW'(1);
         reduce_each_ff  <= 1'b1;
         final_reduce_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (ntt_mm_pkg::csr_index_type'(csr_index))
            ntt_mm_pkg::CSR_MOD_FIRST:    mod_first_ff    <= csr_data;
            ntt_mm_pkg::CSR_MOD_SECOND:   mod_second_ff   <= csr_data;
            ntt_mm_pkg::CSR_REDUCE_EACH:  reduce_each_ff  <= csr_data[0];
            ntt_mm_pkg::CSR_FINAL_REDUCE: final_reduce_ff <= csr_data[0];
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // The whole pipeline advances together; it halts only while the skid
   // register holds a word, so ready comes straight from a flop.
   // ---------------------------------------------------------------------
   logic skid_full_ff;
   logic en;

   assign en        = !skid_full_ff;
   assign req_ready = en;

   // Stage 0: input capture.
   logic            s0_valid_ff;
   logic [CW-1:0]   s0_a_ff, s0_b_ff;
   logic            s0_slot_ff, s0_first_ff, s0_last_ff;
   logic [POSW-1:0] s0_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_a_ff     <= req_left_coeff;
         s0_b_ff     <= req_right_coeff;
         s0_slot_ff  <= req_residue_slot;
         s0_pos_ff   <= req_coeff_position;
         s0_first_ff <= req_first_term;
         s0_last_ff  <= req_last_term;
      end
   end

   // Stage 1: multiply, address formation and modulus selection. Positions
   // beyond the polynomial length wrap by shifted conditional subtraction.
   logic              slot_w;
   logic [RW-1:0]     pos_rem;
   logic [ADDR_W-1:0] s0_idx;

   always_comb begin
      slot_w  = (NUM_SLOTS > 1) ? s0_slot_ff : 1'b0;
      pos_rem = RW'(s0_pos_ff);
      for (int k = POSW - 1; k >= 0; k--) begin
         if (pos_rem >= (RW'(NUM_COEFFS) << k)) begin
            pos_rem = pos_rem - (RW'(NUM_COEFFS) << k);
         end
      end
      s0_idx = ADDR_W'(pos_rem[PW-1:0]) + (slot_w ? ADDR_W'(NUM_COEFFS) : ADDR_W'(0));
   end

   logic              s1_valid_ff;
   logic [SW-1:0]     s1_prod_ff;
   logic [MW-1:0]     s1_mod_ff;
   logic [TAGA_W-1:0] s1_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff <= SW'(s0_a_ff) * SW'(s0_b_ff);
         s1_mod_ff  <= slot_w ? mod_second_ff : mod_first_ff;
         s1_tag_ff  <= {s0_idx, slot_w, s0_slot_ff, s0_pos_ff, s0_first_ff, s0_last_ff};
      end
   end

   // Product remainder pipeline.
   logic              a_valid;
   logic [SW-1:0]     a_value;
   logic [TAGA_W-1:0] a_tag;
   logic [ADDR_W-1:0] a_idx;

   ntt_mm_mod_pipe #(.TAG_W(TAGA_W)) u_prod_mod (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid_ff),
      .in_value  (s1_prod_ff),
      .in_mod    (s1_mod_ff),
      .in_bypass (!reduce_each_ff),
      .in_tag    (s1_tag_ff),
      .out_valid (a_valid),
      .out_value (a_value),
      .out_tag   (a_tag)
   );

   assign a_idx = a_tag[TAGA_W-1 -: ADDR_W];

   // ---------------------------------------------------------------------
   // Accumulator read-modify-write. The read is issued as a word leaves the
   // remainder pipe; the sum is formed and written from the q register stage.
   // Only the word directly ahead can have written the same entry after the
   // read, so its sum is forwarded in place of the RAM data.
   // ---------------------------------------------------------------------
   logic              q_valid_ff;
   logic [SW-1:0]     q_prod_ff;
   logic [TAGA_W-1:0] q_tag_ff;
   logic [ADDR_W-1:0] q_idx;
   logic              q_first;
   logic [SW-1:0]     ram_rd_data;
   logic [SW-1:0]     q_base, q_acc;

   logic              w_valid_ff;
   logic [SW-1:0]     w_acc_ff;
   logic [ADDR_W-1:0] w_idx_ff;
   logic              w_slot_w_ff, w_last_ff;
   logic [TAGB_W-1:0] w_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
         w_valid_ff <= 1'b0;
      end else if (en) begin
         q_valid_ff <= a_valid;
         w_valid_ff <= q_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_prod_ff <= a_value;
         q_tag_ff  <= a_tag;
      end
   end

   assign q_idx   = q_tag_ff[TAGA_W-1 -: ADDR_W];
   assign q_first = q_tag_ff[1];

   always_comb begin
      if (q_first) begin
         q_base = '0;
      end else if (w_valid_ff && (w_idx_ff == q_idx)) begin
         q_base = w_acc_ff;
      end else begin
         q_base = ram_rd_data;
      end
      q_acc = q_base + q_prod_ff;
   end

   ntt_mm_ram #(.WIDTH(SW), .DEPTH(DEPTH), .AW(ADDR_W)) u_acc_ram (
      .clock   (clock),
      .wr_en   (en && q_valid_ff),
      .wr_addr (q_idx),
      .wr_data (q_acc),
      .rd_en   (en),
      .rd_addr (a_idx),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         w_acc_ff    <= q_acc;
         w_idx_ff    <= q_idx;
         w_slot_w_ff <= q_tag_ff[TAGA_W-1-ADDR_W];
         w_last_ff   <= q_tag_ff[0];
         w_tag_ff    <= q_tag_ff[POSW+2:2];
      end
   end

   // Final remainder pipeline; only last-term words travel on.
   logic              b_valid;
   logic [SW-1:0]     b_value;
   logic [TAGB_W-1:0] b_tag;

   ntt_mm_mod_pipe #(.TAG_W(TAGB_W)) u_sum_mod (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (w_valid_ff && w_last_ff),
      .in_value  (w_acc_ff),
      .in_mod    (w_slot_w_ff ? mod_second_ff : mod_first_ff),
      .in_bypass (!final_reduce_ff),
      .in_tag    (w_tag_ff),
      .out_valid (b_valid),
      .out_value (b_value),
      .out_tag   (b_tag)
   );

   // ---------------------------------------------------------------------
   // Output register with a skid register behind it.
   // ---------------------------------------------------------------------
   logic              out_valid_ff;
   logic [SW-1:0]     out_value_ff, skid_value_ff;
   logic [TAGB_W-1:0] out_tag_ff, skid_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp_ready) begin
            skid_full_ff <= 1'b0;
         end
      end else if (!out_valid_ff || rsp_ready) begin
         out_valid_ff <= b_valid;
      end else if (b_valid) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (rsp_ready) begin
            out_value_ff <= skid_value_ff;
            out_tag_ff   <= skid_tag_ff;
         end
      end else if (!out_valid_ff || rsp_ready) begin
         out_value_ff <= b_value;
         out_tag_ff   <= b_tag;
      end else begin
         skid_value_ff <= b_value;
         skid_tag_ff   <= b_tag;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sum_value    = out_value_ff;
   assign rsp_sum_slot     = out_tag_ff[TAGB_W-1];
   assign rsp_sum_position = out_tag_ff[POSW-1:0];

`ifndef SYNTHESIS
   // A word in the skid register always has one in front of it.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   // An accepted request enters the first stage.
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s0_valid_ff)
      else $error("accepted request lost at input stage");

   // While the pipeline is halted the accumulator write stage holds its sum.
   a_halt_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(w_acc_ff) && $stable(w_valid_ff))
      else $error("accumulator stage moved while halted");
`endif

endmodule
